// ===== rtl/core/darm_pkg.sv =====
// ----------------------------------------------------------------------------
// darm_pkg: shared types and constants of the device address range map
// Field widths, command and status codes, and the structs passed between
// the top level and the range cells.
// ----------------------------------------------------------------------------
package darm_pkg;

   localparam int MAX_RANGES_DEFAULT = 16;

   localparam int ADDR_W   = 64;
   localparam int LEN_W    = 64;
   localparam int END_W    = 65;
   localparam int ID_W     = 8;
   localparam int CMD_W    = 2;
   localparam int STATUS_W = 3;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_LOOKUP = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 3'd0,
      STATUS_CONFLICT  = 3'd1,
      STATUS_FULL      = 3'd2,
      STATUS_IN_USE    = 3'd3,
      STATUS_NOT_FOUND = 3'd4
   } status_type;

   // request fields broadcast to every cell
   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic [END_W-1:0]  range_end;
      logic [ID_W-1:0]   device_id;
   } darm_bcast_type;

   // per-cell update strobes
   typedef struct packed {
      logic write;
      logic clear;
   } darm_cell_ctl_type;

   // per-cell compare results
   typedef struct packed {
      logic valid;
      logic clash;
      logic owner_eq;
      logic hit;
   } darm_cell_flags_type;

endpackage

// ===== rtl/core/darm_req_if.sv =====
// ----------------------------------------------------------------------------
// darm_req_if: request channel of the device address range map
// Valid/ready handshake carrying command, address, length and device id.
// ----------------------------------------------------------------------------
interface darm_req_if import darm_pkg::*;;
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [ADDR_W-1:0] address;
   logic [LEN_W-1:0]  length;
   logic [ID_W-1:0]   device_id;

   modport source (output valid, output cmd, output address, output length,
                   output device_id, input ready);
   modport sink   (input valid, input cmd, input address, input length,
                   input device_id, output ready);
endinterface

// ===== rtl/core/darm_rsp_if.sv =====
// ----------------------------------------------------------------------------
// darm_rsp_if: response channel of the device address range map
// Valid/ready handshake carrying status, found device id and recent-hit flag.
// ----------------------------------------------------------------------------
interface darm_rsp_if import darm_pkg::*;;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ID_W-1:0]     found_id;
   logic                from_recent;

   modport source (output valid, output status, output found_id,
                   output from_recent, input ready);
   modport sink   (input valid, input status, input found_id,
                   input from_recent, output ready);
endinterface

// ===== rtl/core/darm_cell.sv =====
// ----------------------------------------------------------------------------
// darm_cell: one entry of the range table
// Holds base, 65-bit end and owner of a range and compares them against the
// broadcast request every cycle, registering the results.
// ----------------------------------------------------------------------------
module darm_cell import darm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  darm_bcast_type      bcast,
   input  darm_cell_ctl_type   ctl,
   output darm_cell_flags_type flags_ff,
   output logic [ID_W-1:0]     owner_ff
);

   logic [ADDR_W-1:0]   base_ff;
   logic [END_W-1:0]    end_ff;
   logic                valid_ff;
   darm_cell_flags_type flags_in;
   logic                new_first;

   always_comb begin
      // new range starts at or below this one
      new_first         = bcast.address <= base_ff;
      flags_in.valid    = valid_ff;
      flags_in.clash    = valid_ff && (new_first ? ({1'b0, base_ff} < bcast.range_end)
                                                 : ({1'b0, bcast.address} < end_ff));
      flags_in.owner_eq = valid_ff && (owner_ff == bcast.device_id);
      flags_in.hit      = valid_ff && (base_ff <= bcast.address)
                          && ({1'b0, bcast.address} < end_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.write) begin
         valid_ff <= 1'b1;
      end else if (ctl.clear) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.write) begin
         base_ff  <= bcast.address;
         end_ff   <= bcast.range_end;
         owner_ff <= bcast.device_id;
      end
      flags_ff <= flags_in;
   end

endmodule

// ===== rtl/core/device_address_range_map_unit.sv =====
// ----------------------------------------------------------------------------
// device_address_range_map_unit: device address range map
// Table of non-overlapping address ranges owned by device ids, with insert,
// remove by id and address lookup through a most-recently-used entry.
// ----------------------------------------------------------------------------
// Each request passes through an accept state, an evaluate state in which every
// range cell compares the request against its entry in parallel and registers
// the result, and a commit state that picks the lowest matching cell, updates
// the table and loads the response register. The commit waits while an
// earlier response has not been taken; a new request is accepted while a
// response waits. Range ends are kept at 65 bits so ranges never wrap.
// Insert is refused as conflict, then table full, then id in use; remove of
// an unknown id and unused commands answer not found. Lookup checks the
// most-recently-used entry first, then the lowest hitting cell, which then
// becomes the most-recently-used one. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module device_address_range_map_unit import darm_pkg::*; #(
   parameter int MAX_RANGES = MAX_RANGES_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   darm_req_if.sink  req_chan,
   darm_rsp_if.source rsp_chan
);

   localparam int SlotW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
   localparam logic [MAX_RANGES-1:0] OneVec = MAX_RANGES'(1);

   typedef enum logic [1:0] {S_IDLE, S_EVAL, S_COMMIT} state_type;

   state_type         state_ff;

   // captured request
   cmd_type           cmd_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [END_W-1:0]  end_ff;
   logic [ID_W-1:0]   id_ff;

   // most-recently-used pointer
   logic [SlotW-1:0]  recent_slot_ff;
   logic              recent_valid_ff;

   // response register
   logic              rsp_valid_ff;
   status_type        rsp_status_ff;
   logic [ID_W-1:0]   rsp_found_ff;
   logic              rsp_recent_ff;

   // cell row
   darm_bcast_type      bcast;
   darm_cell_ctl_type   ctl    [MAX_RANGES];
   darm_cell_flags_type flags  [MAX_RANGES];
   logic [ID_W-1:0]     owners [MAX_RANGES];

   logic [MAX_RANGES-1:0] valid_vec, clash_vec, own_vec, hit_vec, free_vec;
   logic [MAX_RANGES-1:0] free_pick, own_pick, hit_pick;
   logic [SlotW-1:0]      own_idx, hit_idx;
   logic [ID_W-1:0]       hit_owner;
   logic                  recent_hit;

   // commit decision
   logic                  commit_go;
   status_type            status_res;
   logic [ID_W-1:0]       found_res;
   logic                  recent_res;
   logic                  do_write, do_clear, set_recent, drop_recent;

   assign req_chan.ready       = (state_ff == S_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.found_id    = rsp_found_ff;
   assign rsp_chan.from_recent = rsp_recent_ff;

   assign bcast.address   = addr_ff;
   assign bcast.range_end = end_ff;
   assign bcast.device_id = id_ff;

   for (genvar g = 0; g < MAX_RANGES; g++) begin : g_cell
      darm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .bcast    (bcast),
         .ctl      (ctl[g]),
         .flags_ff (flags[g]),
         .owner_ff (owners[g])
      );
   end

   // gather cell flags into vectors
   always_comb begin
      for (int i = 0; i < MAX_RANGES; i++) begin
         valid_vec[i] = flags[i].valid;
         clash_vec[i] = flags[i].clash;
         own_vec[i]   = flags[i].owner_eq;
         hit_vec[i]   = flags[i].hit;
      end
   end

   // lowest set bit of each vector
   assign free_vec  = ~valid_vec;
   assign free_pick = free_vec & (~free_vec + OneVec);
   assign own_pick  = own_vec & (~own_vec + OneVec);
   assign hit_pick  = hit_vec & (~hit_vec + OneVec);

   // one-hot to slot number, and owner of the lowest hit
   always_comb begin
      own_idx   = '0;
      hit_idx   = '0;
      hit_owner = '0;
      for (int i = 0; i < MAX_RANGES; i++) begin
         if (own_pick[i]) begin
            own_idx = own_idx | SlotW'(i);
         end
         if (hit_pick[i]) begin
            hit_idx = hit_idx | SlotW'(i);
         end
         hit_owner = hit_owner | (owners[i] & {ID_W{hit_pick[i]}});
      end
   end

   // hit flag already includes the entry's valid bit
   assign recent_hit = recent_valid_ff && hit_vec[recent_slot_ff];

   assign commit_go = (state_ff == S_COMMIT) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      status_res  = STATUS_NOT_FOUND;
      found_res   = '0;
      recent_res  = 1'b0;
      do_write    = 1'b0;
      do_clear    = 1'b0;
      set_recent  = 1'b0;
      drop_recent = 1'b0;
      unique case (cmd_ff)
         CMD_INSERT: begin
            if (|clash_vec) begin
               status_res = STATUS_CONFLICT;
            end else if (!(|free_vec)) begin
               status_res = STATUS_FULL;
            end else if (|own_vec) begin
               status_res = STATUS_IN_USE;
            end else begin
               status_res = STATUS_OK;
               do_write   = 1'b1;
            end
         end
         CMD_REMOVE: begin
            if (|own_vec) begin
               status_res  = STATUS_OK;
               do_clear    = 1'b1;
               drop_recent = recent_valid_ff && (recent_slot_ff == own_idx);
            end
         end
         CMD_LOOKUP: begin
            if (recent_hit) begin
               status_res = STATUS_OK;
               found_res  = owners[recent_slot_ff];
               recent_res = 1'b1;
            end else if (|hit_vec) begin
               status_res = STATUS_OK;
               found_res  = hit_owner;
               set_recent = 1'b1;
            end
         end
         default: begin
            status_res = STATUS_NOT_FOUND;
         end
      endcase
   end

   // write strobe to the lowest free cell, clear strobe to the owner's cell
   always_comb begin
      for (int i = 0; i < MAX_RANGES; i++) begin
         ctl[i].write = commit_go && do_write && free_pick[i];
         ctl[i].clear = commit_go && do_clear && own_pick[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         rsp_valid_ff    <= 1'b0;
         recent_valid_ff <= 1'b0;
         recent_slot_ff  <= '0;
      end else begin
         // response loaded at commit, dropped once taken
         if (commit_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_chan.valid) begin
                  cmd_ff   <= cmd_type'(req_chan.cmd);
                  addr_ff  <= req_chan.address;
                  // end of the new range at 65 bits
                  end_ff   <= {1'b0, req_chan.address} + {1'b0, req_chan.length};
                  id_ff    <= req_chan.device_id;
                  state_ff <= S_EVAL;
               end
            end
            S_EVAL: begin
               // cells register their compare results this cycle
               state_ff <= S_COMMIT;
            end
            S_COMMIT: begin
               if (commit_go) begin
                  rsp_status_ff <= status_res;
                  rsp_found_ff  <= found_res;
                  rsp_recent_ff <= recent_res;
                  if (set_recent) begin
                     recent_slot_ff  <= hit_idx;
                     recent_valid_ff <= 1'b1;
                  end else if (drop_recent) begin
                     recent_valid_ff <= 1'b0;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== rtl/core/darm_checker.sv =====
// ----------------------------------------------------------------------------
// darm_checker: port-level assertions of the device address range map
// Watches the request and response channels and is bound to the top level.
// ----------------------------------------------------------------------------
module darm_checker import darm_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [ID_W-1:0]     rsp_found_id,
   input logic                rsp_from_recent
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_found_id) && $stable(rsp_from_recent))
      else $error("response changed while stalled");

   // a recent hit is always a successful lookup
   a_recent_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_from_recent |-> rsp_status == STATUS_OK)
      else $error("recent hit without ok status");

   // failed requests report no device
   a_fail_no_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_found_id == '0)
      else $error("device id on failed request");

   // a new response follows a cycle with a request in flight
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response without a request in flight");

endmodule

bind device_address_range_map_unit darm_checker u_darm_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_status      (rsp_chan.status),
   .rsp_found_id    (rsp_chan.found_id),
   .rsp_from_recent (rsp_chan.from_recent)
);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for device_address_range_map_unit
// Drives insert, remove, lookup and unused requests through the request
// channel with random gaps and response back-pressure. A scoreboard keeps
// its own copy of the range table and the most-recently-used entry,
// predicts every response and compares each one field by field.
// ----------------------------------------------------------------------------
module testbench;
   import darm_pkg::*;

   localparam int TABLE_SLOTS   = MAX_RANGES_DEFAULT;
   localparam int RANDOM_COUNT  = 1050;
   localparam int STALL_LIMIT   = 2000;
   localparam int DRAIN_CYCLES  = 20;
   localparam int HOLD_START    = 1500;
   localparam int HOLD_CYCLES   = 300;
   localparam int CALM_RX_START = 2200;
   localparam int CALM_RX_END   = 2800;
   localparam int CALM_TX_START = 500;
   localparam int CALM_TX_END   = 700;
   localparam int REGION_COUNT  = 20;
   localparam int ID_POOL       = 20;

   // the one command code the package leaves unnamed
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct {
      status_type      status;
      logic [ID_W-1:0] found_id;
      logic            from_recent;
   } map_reply_type;

   // predicted range table plus the queue of responses still owed
   class range_map_scoreboard;
      logic [ADDR_W-1:0] slot_base   [TABLE_SLOTS];
      logic [LEN_W-1:0]  slot_length [TABLE_SLOTS];
      logic [ID_W-1:0]   slot_owner  [TABLE_SLOTS];
      bit                slot_live   [TABLE_SLOTS];
      int unsigned       mru_slot;
      bit                mru_live;
      map_reply_type     owed_replies[$];
      int unsigned       errors;

      function new();
         for (int s = 0; s < TABLE_SLOTS; s++) begin
            slot_base[s]   = '0;
            slot_length[s] = '0;
            slot_owner[s]  = '0;
            slot_live[s]   = 1'b0;
         end
         mru_slot = 0;
         mru_live = 1'b0;
         errors   = 0;
      endfunction

      // a < base + len, the sum carried to 65 bits
      function bit below_end(logic [ADDR_W-1:0] a, logic [ADDR_W-1:0] base,
                             logic [LEN_W-1:0] len);
         logic [END_W-1:0] stop;
         stop = {1'b0, base} + {1'b0, len};
         return {1'b0, a} < stop;
      endfunction

      function bit covers(int s, logic [ADDR_W-1:0] a);
         return slot_base[s] <= a && below_end(a, slot_base[s], slot_length[s]);
      endfunction

      function bit overlaps(int s, logic [ADDR_W-1:0] x, logic [LEN_W-1:0] l);
         if (x <= slot_base[s])
            return below_end(slot_base[s], x, l);
         return below_end(x, slot_base[s], slot_length[s]);
      endfunction

      function void note_request(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] address,
                                 logic [LEN_W-1:0] length, logic [ID_W-1:0] id);
         map_reply_type reply;
         bit            clash_seen;
         bit            id_taken;
         bit            have_free;
         bit            done;
         int            free_slot;
         reply.status      = STATUS_NOT_FOUND;
         reply.found_id    = '0;
         reply.from_recent = 1'b0;
         clash_seen = 1'b0;
         id_taken   = 1'b0;
         have_free  = 1'b0;
         done       = 1'b0;
         free_slot  = 0;
         case (cmd)
            CMD_INSERT: begin
               for (int s = 0; s < TABLE_SLOTS; s++) begin
                  if (slot_live[s]) begin
                     if (overlaps(s, address, length)) clash_seen = 1'b1;
                     if (slot_owner[s] == id) id_taken = 1'b1;
                  end else if (!have_free) begin
                     have_free = 1'b1;
                     free_slot = s;
                  end
               end
               // refusal order: conflict, then full, then id in use
               if (clash_seen)
                  reply.status = STATUS_CONFLICT;
               else if (!have_free)
                  reply.status = STATUS_FULL;
               else if (id_taken)
                  reply.status = STATUS_IN_USE;
               else begin
                  slot_base[free_slot]   = address;
                  slot_length[free_slot] = length;
                  slot_owner[free_slot]  = id;
                  slot_live[free_slot]   = 1'b1;
                  reply.status = STATUS_OK;
               end
            end
            CMD_REMOVE: begin
               for (int s = 0; s < TABLE_SLOTS; s++) begin
                  if (!done && slot_live[s] && slot_owner[s] == id) begin
                     slot_live[s] = 1'b0;
                     if (mru_live && mru_slot == s) mru_live = 1'b0;
                     reply.status = STATUS_OK;
                     done = 1'b1;
                  end
               end
            end
            CMD_LOOKUP: begin
               if (mru_live && slot_live[mru_slot] && covers(mru_slot, address)) begin
                  reply.status      = STATUS_OK;
                  reply.found_id    = slot_owner[mru_slot];
                  reply.from_recent = 1'b1;
               end else begin
                  for (int s = 0; s < TABLE_SLOTS; s++) begin
                     if (!done && slot_live[s] && covers(s, address)) begin
                        reply.status   = STATUS_OK;
                        reply.found_id = slot_owner[s];
                        mru_slot = s;
                        mru_live = 1'b1;
                        done = 1'b1;
                     end
                  end
               end
            end
            default: ;
         endcase
         owed_replies.push_back(reply);
      endfunction

      function void check_response(logic [STATUS_W-1:0] status,
                                   logic [ID_W-1:0] found_id, logic from_recent);
         map_reply_type want;
         if (owed_replies.size() == 0) begin
            errors++;
            $display("%0t: response with none owed: status %0d id %0d recent %0b",
                     $time, status, found_id, from_recent);
            return;
         end
         // oldest owed response
         want = owed_replies[0];
         owed_replies.delete(0);
         if (status !== want.status || found_id !== want.found_id ||
             from_recent !== want.from_recent) begin
            errors++;
            $display("%0t: expected status %0d id %0d recent %0b, got %0d id %0d recent %0b",
                     $time, want.status, want.found_id, want.from_recent,
                     status, found_id, from_recent);
         end
      endfunction

      function int unsigned outstanding();
         return owed_replies.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   darm_req_if req_bus ();
   darm_rsp_if rsp_bus ();

   device_address_range_map_unit #(
      .MAX_RANGES (TABLE_SLOTS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   range_map_scoreboard map_board;
   int unsigned         quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // offer one request from a falling edge and hold it until taken;
   // may_idle lets the sender drop valid for a random number of cycles after
   task automatic send_request(input logic [CMD_W-1:0] cmd,
                               input logic [ADDR_W-1:0] address,
                               input logic [LEN_W-1:0] length,
                               input logic [ID_W-1:0] id, input bit may_idle);
      req_bus.valid     <= 1'b1;
      req_bus.cmd       <= cmd;
      req_bus.address   <= address;
      req_bus.length    <= length;
      req_bus.device_id <= id;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      @(negedge clock);
      // each further idle cycle is drawn with a chance of 28 in a hundred
      while (may_idle && $urandom_range(0, 99) < 28) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
   endtask

   // sample both handshakes at the rising edge; the watchdog counts edges
   // at which neither channel moved anything
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            map_board.note_request(req_bus.cmd, req_bus.address, req_bus.length,
                                   req_bus.device_id);
         if (rsp_bus.valid && rsp_bus.ready)
            map_board.check_response(rsp_bus.status, rsp_bus.found_id,
                                     rsp_bus.from_recent);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles <= 0;
         else if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("device_address_range_map_unit verification failed");
            $finish;
         end else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   // response side: random back-pressure, one long hold-off so the block
   // backs up into its request port, and a calm window with no stalls
   initial begin : response_sink
      int unsigned sink_cycle;
      rsp_bus.ready = 1'b0;
      sink_cycle = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (sink_cycle >= HOLD_START && sink_cycle < HOLD_START + HOLD_CYCLES)
            rsp_bus.ready <= 1'b0;
         else if (sink_cycle >= CALM_RX_START && sink_cycle < CALM_RX_END)
            rsp_bus.ready <= 1'b1;
         else
            rsp_bus.ready <= ($urandom_range(0, 99) >= 28);
         sink_cycle++;
         @(negedge clock);
      end
   end

   initial begin : request_source
      logic [CMD_W-1:0]  cmd;
      logic [ADDR_W-1:0] address;
      logic [LEN_W-1:0]  length;
      logic [ID_W-1:0]   id;
      int unsigned       pick;
      int unsigned       remove_weight;
      int                probe;
      bit                got_slot;

      map_board    = new();
      quiet_cycles = 0;
      reset = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.cmd       = CMD_INSERT;
      req_bus.address   = '0;
      req_bus.length    = '0;
      req_bus.device_id = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // directed part
      // empty table: lookup, remove of unknown id, unused command
      send_request(CMD_LOOKUP, 64'h0, 64'h0, 8'd0, 1'b1);
      send_request(CMD_REMOVE, 64'h0, 64'h0, 8'd5, 1'b1);
      send_request(CMD_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                   8'hFF, 1'b1);
      send_request(CMD_INSERT, 64'h1000, 64'h100, 8'd1, 1'b1);
      // new range inside a stored one, and one reaching a stored base
      send_request(CMD_INSERT, 64'h10FF, 64'h1, 8'd2, 1'b1);
      send_request(CMD_INSERT, 64'h0F00, 64'h101, 8'd2, 1'b1);
      // adjacent range below is fine
      send_request(CMD_INSERT, 64'h0F00, 64'h100, 8'd2, 1'b1);
      // clean range with an id already stored
      send_request(CMD_INSERT, 64'h2000, 64'h10, 8'd1, 1'b1);
      // zero-length at a stored base is allowed, strictly inside is not
      send_request(CMD_INSERT, 64'h1000, 64'h0, 8'd3, 1'b1);
      send_request(CMD_INSERT, 64'h1080, 64'h0, 8'd4, 1'b1);
      // range whose end lies past the top of the address space
      send_request(CMD_INSERT, 64'hFFFF_FFFF_FFFF_FF00, 64'hFFFF_FFFF_FFFF_FFFF,
                   8'hFF, 1'b1);
      send_request(CMD_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 8'd0, 1'b1);
      send_request(CMD_LOOKUP, 64'hFFFF_FFFF_FFFF_FF00, 64'h0, 8'd0, 1'b1);
      // zero-length range never holds its base
      send_request(CMD_LOOKUP, 64'h1000, 64'h0, 8'd0, 1'b1);
      send_request(CMD_LOOKUP, 64'h10FF, 64'h0, 8'd0, 1'b1);
      send_request(CMD_LOOKUP, 64'h1100, 64'h0, 8'd0, 1'b1);
      send_request(CMD_LOOKUP, 64'h0FFF, 64'h0, 8'd0, 1'b1);
      // range covering all but the top address clashes with everything
      send_request(CMD_INSERT, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0, 1'b1);
      // removing the most-recently-used owner drops the recent entry
      send_request(CMD_REMOVE, 64'h0, 64'h0, 8'd2, 1'b1);
      send_request(CMD_LOOKUP, 64'h0FFF, 64'h0, 8'd0, 1'b1);
      send_request(CMD_INSERT, 64'h0, 64'h10, 8'd0, 1'b1);
      send_request(CMD_LOOKUP, 64'h0, 64'h0, 8'd0, 1'b1);
      send_request(CMD_REMOVE, 64'h0, 64'h0, 8'hFF, 1'b1);
      send_request(CMD_REMOVE, 64'h0, 64'h0, 8'd3, 1'b1);

      // random part: well-formed ranges on a region grid, lookups aimed
      // at stored ranges and their edges, plus noise
      for (int n = 0; n < RANDOM_COUNT; n++) begin
         // few removes early so the table fills, more later
         remove_weight = (n < RANDOM_COUNT / 2) ? 5 : 20;
         pick   = $urandom_range(0, 99);
         length = '0;
         id     = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, ID_POOL - 1))
                                              : 8'($urandom_range(0, 255));
         if (pick < 35) begin
            cmd  = CMD_INSERT;
            pick = $urandom_range(0, 99);
            address = (64'($urandom_range(0, REGION_COUNT - 1)) << 24)
                      + 64'($urandom_range(0, 16'hFFFF));
            if (pick < 70)
               length = 64'($urandom_range(1, 24'hFF_FFFF));
            else if (pick < 80)
               length = '0;
            else if (pick < 90)
               length = {$urandom, $urandom};
            else begin
               // near the top, often running past it
               address = {32'hFFFF_FFFF, $urandom};
               length  = {$urandom, $urandom};
            end
         end else if (pick < 35 + remove_weight) begin
            cmd     = CMD_REMOVE;
            address = {$urandom, $urandom};
         end else if (pick < 95) begin
            cmd      = CMD_LOOKUP;
            address  = {$urandom, $urandom};
            got_slot = 1'b0;
            probe    = $urandom_range(0, TABLE_SLOTS - 1);
            for (int k = 0; k < TABLE_SLOTS; k++) begin
               if (!got_slot && map_board.slot_live[(probe + k) % TABLE_SLOTS]) begin
                  got_slot = 1'b1;
                  probe    = (probe + k) % TABLE_SLOTS;
               end
            end
            if (got_slot && $urandom_range(0, 99) < 85) begin
               case ($urandom_range(0, 4))
                  0: address = map_board.slot_base[probe];
                  1: address = map_board.slot_base[probe] + map_board.slot_length[probe] - 1;
                  2: address = map_board.slot_base[probe] - 1;
                  3: address = map_board.slot_base[probe] + map_board.slot_length[probe];
                  default:
                     address = map_board.slot_base[probe] +
                               ((map_board.slot_length[probe] == 0) ? 64'h0 :
                                {$urandom, $urandom} % map_board.slot_length[probe]);
               endcase
            end
         end else begin
            cmd     = CMD_UNUSED;
            address = {$urandom, $urandom};
            length  = {$urandom, $urandom};
         end
         send_request(cmd, address, length, id,
                      !(n >= CALM_TX_START && n < CALM_TX_END));
      end
      req_bus.valid <= 1'b0;

      // drain, then give the pipeline time to show any stray response
      while (map_board.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (map_board.errors == 0 && map_board.outstanding() == 0)
         $display("device_address_range_map_unit verification clean");
      else
         $display("device_address_range_map_unit verification failed");
      $finish;
   end

endmodule
